>>> rtl/core/edd_pkg.sv
// Package for the error diffusion dither: pixel transaction types, field widths,
// the reset value of the width register and the table of output levels.
// Depends on nothing; used by the top level, the checker and the testbench.
`default_nettype none

package edd_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned ERR_W     = 10;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned LEVEL_NUM = 27;
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned MAX_WIDTH_DEFAULT = 1024;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;

  // Output value of each quantiser level: floor(q * 255 / 26).
  localparam logic [CHAN_W-1:0] LEVEL_VALUE [LEVEL_NUM] = '{
    8'd0,   8'd9,   8'd19,  8'd29,  8'd39,  8'd49,  8'd58,  8'd68,  8'd78,
    8'd88,  8'd98,  8'd107, 8'd117, 8'd127, 8'd137, 8'd147, 8'd156, 8'd166,
    8'd176, 8'd186, 8'd196, 8'd205, 8'd215, 8'd225, 8'd235, 8'd245, 8'd255
  };

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
    logic              frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } pix_out_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_LAST = 3'b100
  } state_e;

  // Level index of a clamped value: (c*26 + 127) / 255, computed as
  // ((t + 1) * 257) >> 16, which is exact for every t that can occur here.
  function automatic logic [LEVEL_W-1:0] level_index(input logic [CHAN_W-1:0] c);
    logic [12:0] t;
    logic [20:0] p;
    t = 13'({5'd0, c} * 13'd26) + 13'd127;
    p = 21'({8'd0, t} + 21'd1) * 21'd257;
    return p[20:16];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/edd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module edd_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/error_diffusion_dither_rgb.sv
// Error diffusion dither top level: 27-level Floyd-Steinberg quantiser for RGB.
// Depends on edd_pkg and on edd_ram for the line of errors kept for the next row.
// A pixel is taken only in IDLE; its result is registered on leaving CALC, which holds
// while the output stalls, and the last pixel of a row passes LAST before IDLE. The line
// memory is read, modified and written back through its single write port per pixel.
// Reset: asynchronous, active low; width returns to 1024, carries clear, no memory sweep.
`default_nettype none

module error_diffusion_dither_rgb #(
  parameter int unsigned MAX_WIDTH = edd_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire edd_pkg::pix_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output edd_pkg::pix_out_t                 out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [edd_pkg::WIDTH_W-1:0]  cfg_data_i
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W  = ((COL_W > edd_pkg::WIDTH_W) ? COL_W : edd_pkg::WIDTH_W) + 1;
  localparam int unsigned ERR_W  = edd_pkg::ERR_W;
  localparam int unsigned NCH    = edd_pkg::NUM_CHAN;
  localparam int unsigned LINE_W = ERR_W * NCH;
  localparam int unsigned V_W    = 11;   // pixel plus carried errors, signed
  localparam int unsigned P_W    = 15;   // error times a weight, signed

  // ------------------------------------------------------------------------
  // Sequencer. A pixel is taken only in IDLE; the line entry for its column
  // is read at the same edge. In CALC the read data is valid, the result is
  // formed and the left neighbour's entry is written back. The last pixel of
  // a row needs a second write for its own column, done in LAST.
  // ------------------------------------------------------------------------
  edd_pkg::state_e state_q, state_d;

  logic [edd_pkg::WIDTH_W-1:0] width_q;
  logic [COL_W-1:0]            column_q;
  logic                        first_row_q;

  logic signed [ERR_W-1:0] right_q [NCH];
  logic signed [ERR_W-1:0] pleft_q [NCH];
  logic signed [ERR_W-1:0] phere_q [NCH];

  edd_pkg::pix_in_t  pix_q;
  logic [COL_W-1:0]  x_q;
  logic              last_q;
  logic [LINE_W-1:0] wr_last_q;

  edd_pkg::pix_out_t out_q;
  logic              out_valid_q;

  logic in_take;
  logic out_free;
  logic calc_go;

  assign in_ready_o  = (state_q == edd_pkg::S_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign calc_go     = (state_q == edd_pkg::S_CALC) && out_free;
  assign cfg_ready_o = 1'b1;

  // ------------------------------------------------------------------------
  // Effective width and column. A width of zero behaves as one and a width
  // above the line memory's depth behaves as that depth. If the width has
  // been lowered under a running row, the pixel is taken as the row's last.
  // ------------------------------------------------------------------------
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_ext;
  logic [CMP_W-1:0] x_ext;
  logic [COL_W-1:0] x_new;
  logic             last_new;

  always_comb begin
    width_ext = CMP_W'(width_q);
    if (width_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    col_ext = in_data_i.frame_start ? '0 : CMP_W'(column_q);
    if (col_ext >= width_eff) begin
      x_ext = width_eff - CMP_W'(1);
    end else begin
      x_ext = col_ext;
    end
    x_new    = x_ext[COL_W-1:0];
    last_new = (x_ext == width_eff - CMP_W'(1));
  end

  // ------------------------------------------------------------------------
  // Line memory: one entry per column, three signed error values per entry,
  // red in the lowest bits. Reads and writes never meet on one entry in the
  // same cycle, because a pixel is read only once the previous one has
  // finished all its writes.
  // ------------------------------------------------------------------------
  logic [LINE_W-1:0] line_rdata;
  logic [LINE_W-1:0] line_wdata;
  logic [COL_W-1:0]  line_waddr;
  logic              line_we;
  logic [LINE_W-1:0] calc_wdata;

  always_comb begin
    line_we    = 1'b0;
    line_waddr = x_q - COL_W'(1);
    line_wdata = calc_wdata;
    if (calc_go && (x_q != '0)) begin
      line_we = 1'b1;
    end else if (state_q == edd_pkg::S_LAST) begin
      line_we    = 1'b1;
      line_waddr = x_q;
      line_wdata = wr_last_q;
    end
  end

  edd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (in_take),
    .raddr_i (x_new),
    .rdata_o (line_rdata)
  );

  // ------------------------------------------------------------------------
  // Per-channel datapath: add the carried errors, clamp, quantise through the
  // level table, and split the error into its four weighted shares. Each
  // share truncates towards zero, as signed integer division does.
  // ------------------------------------------------------------------------
  function automatic logic signed [ERR_W-1:0] share16(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] b;
    b = p + ((p < 0) ? P_W'(15) : P_W'(0));
    return ERR_W'(b >>> 4);
  endfunction

  logic [edd_pkg::CHAN_W-1:0]  chan_in  [NCH];
  logic [edd_pkg::CHAN_W-1:0]  chan_out [NCH];
  logic signed [ERR_W-1:0]     sh1 [NCH];
  logic signed [ERR_W-1:0]     sh3 [NCH];
  logic signed [ERR_W-1:0]     sh5 [NCH];
  logic signed [ERR_W-1:0]     sh7 [NCH];
  logic [LINE_W-1:0]           last_wdata;

  assign chan_in[0] = pix_q.red_in;
  assign chan_in[1] = pix_q.green_in;
  assign chan_in[2] = pix_q.blue_in;

  for (genvar ch = 0; ch < NCH; ch++) begin : g_chan
    logic signed [ERR_W-1:0]      above;
    logic signed [V_W-1:0]        v;
    logic [edd_pkg::CHAN_W-1:0]   clamped;
    logic [edd_pkg::LEVEL_W-1:0]  lvl;
    logic signed [P_W-1:0]        e;

    always_comb begin
      above = first_row_q ? '0 : $signed(line_rdata[ch*ERR_W +: ERR_W]);
      v = $signed(V_W'(chan_in[ch])) + V_W'(above) + V_W'(right_q[ch]);
      if (v < 0) begin
        clamped = '0;
      end else if (v > V_W'(255)) begin
        clamped = '1;
      end else begin
        clamped = v[edd_pkg::CHAN_W-1:0];
      end
      lvl          = edd_pkg::level_index(clamped);
      chan_out[ch] = edd_pkg::LEVEL_VALUE[lvl];
      e   = P_W'(v) - $signed(P_W'(chan_out[ch]));
      sh1[ch] = share16(e);
      sh3[ch] = share16(P_W'(e * P_W'(3)));
      sh5[ch] = share16(P_W'(e * P_W'(5)));
      sh7[ch] = share16(P_W'(e * P_W'(7)));
      calc_wdata[ch*ERR_W +: ERR_W] = ERR_W'(pleft_q[ch] + sh3[ch]);
      last_wdata[ch*ERR_W +: ERR_W] = ERR_W'(phere_q[ch] + sh5[ch]);
    end
  end

  // ------------------------------------------------------------------------
  // Next state.
  // ------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      edd_pkg::S_IDLE: begin
        if (in_take) begin
          state_d = edd_pkg::S_CALC;
        end
      end
      edd_pkg::S_CALC: begin
        if (calc_go) begin
          state_d = last_q ? edd_pkg::S_LAST : edd_pkg::S_IDLE;
        end
      end
      edd_pkg::S_LAST: begin
        state_d = edd_pkg::S_IDLE;
      end
      default: begin
        state_d = edd_pkg::S_IDLE;
      end
    endcase
  end

  // Control state and carried errors.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= edd_pkg::S_IDLE;
      width_q     <= edd_pkg::WIDTH_RESET;
      column_q    <= '0;
      first_row_q <= 1'b1;
      out_valid_q <= 1'b0;
      for (int ch = 0; ch < NCH; ch++) begin
        right_q[ch] <= '0;
        pleft_q[ch] <= '0;
        phere_q[ch] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        width_q <= cfg_data_i;
      end
      if (calc_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // A new frame restarts the column and drops every carried error.
      if (in_take && in_data_i.frame_start) begin
        first_row_q <= 1'b1;
        for (int ch = 0; ch < NCH; ch++) begin
          right_q[ch] <= '0;
          pleft_q[ch] <= '0;
          phere_q[ch] <= '0;
        end
      end
      if (calc_go) begin
        if (last_q) begin
          column_q    <= '0;
          first_row_q <= 1'b0;
          for (int ch = 0; ch < NCH; ch++) begin
            right_q[ch] <= '0;
            pleft_q[ch] <= '0;
            phere_q[ch] <= '0;
          end
        end else begin
          column_q <= x_q + COL_W'(1);
          for (int ch = 0; ch < NCH; ch++) begin
            right_q[ch] <= sh7[ch];
            pleft_q[ch] <= ERR_W'(phere_q[ch] + sh5[ch]);
            phere_q[ch] <= sh1[ch];
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q  <= in_data_i;
      x_q    <= x_new;
      last_q <= last_new;
    end
    if (calc_go) begin
      wr_last_q       <= last_wdata;
      out_q.red_out   <= chan_out[0];
      out_q.green_out <= chan_out[1];
      out_q.blue_out  <= chan_out[2];
      out_q.alpha_out <= pix_q.alpha_in;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
  a_take_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == edd_pkg::S_CALC))
    else $error("accepted pixel did not move to the calculation state");

  a_last_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == edd_pkg::S_LAST) |-> ($past(state_q) == edd_pkg::S_CALC) && $past(last_q))
    else $error("end-of-row write without a preceding last pixel");

  a_result_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == edd_pkg::S_CALC))
    else $error("result appeared outside the calculation state");

  a_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_we |-> ((state_q == edd_pkg::S_CALC) || (state_q == edd_pkg::S_LAST)))
    else $error("line memory written while idle");

  a_no_read_during_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_we |-> !in_take)
    else $error("line memory read and written in the same cycle");

endmodule

`default_nettype wire

>>> test/edd_dither_checker.sv
`timescale 1ns / 1ps
// Checker for the error diffusion dither: predicts every dithered pixel from the
// accepted input transactions and compares it with the output transactions.
// Depends on edd_pkg for the pixel transaction types and the field widths.
module edd_dither_checker #(
  parameter int unsigned MAX_WIDTH = edd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  edd_pkg::pix_in_t            in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  edd_pkg::pix_out_t           out_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [edd_pkg::WIDTH_W-1:0] cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  localparam int LEVEL_STEPS = 26;
  localparam int FULL_SCALE  = 255;
  localparam int ROUND_HALF  = 127;
  localparam int COL_W       = $clog2(MAX_WIDTH);

  typedef logic signed [edd_pkg::ERR_W-1:0] err_t;

  // Error state of the diffusion, one value per colour channel.
  err_t                        err_line    [MAX_WIDTH][edd_pkg::NUM_CHAN];
  err_t                        carry_right [edd_pkg::NUM_CHAN];
  err_t                        part_left   [edd_pkg::NUM_CHAN];
  err_t                        part_here   [edd_pkg::NUM_CHAN];
  logic [COL_W-1:0]            col_pos;
  logic                        top_row;
  logic [edd_pkg::WIDTH_W-1:0] width_reg;
  edd_pkg::pix_out_t           dithered_pixels [$];

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      for (int c = 0; c < edd_pkg::NUM_CHAN; c++) begin
        err_line[i][c] = '0;
      end
    end
    for (int c = 0; c < edd_pkg::NUM_CHAN; c++) begin
      carry_right[c] = '0;
      part_left[c]   = '0;
      part_here[c]   = '0;
    end
    col_pos      = '0;
    top_row      = 1'b1;
    width_reg    = edd_pkg::WIDTH_RESET;
  end

  function automatic logic [edd_pkg::CHAN_W-1:0] nearest_level(input int v);
    int c;
    int q;
    c = (v < 0) ? 0 : ((v > FULL_SCALE) ? FULL_SCALE : v);
    q = (c * LEVEL_STEPS + ROUND_HALF) / FULL_SCALE;
    return edd_pkg::CHAN_W'((q * FULL_SCALE) / LEVEL_STEPS);
  endfunction

  // Dithers one pixel and moves the error state on by one column, or to the next row.
  task automatic dither_pixel(input edd_pkg::pix_in_t px, output edd_pkg::pix_out_t res);
    int                         w;
    int                         x;
    int                         ch;
    int                         above;
    int                         sum;
    int                         e;
    bit                         last;
    logic [edd_pkg::CHAN_W-1:0] chan_in  [edd_pkg::NUM_CHAN];
    logic [edd_pkg::CHAN_W-1:0] chan_out [edd_pkg::NUM_CHAN];
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > int'(MAX_WIDTH)) w = MAX_WIDTH;
    if (px.frame_start) begin
      col_pos = '0;
      top_row = 1'b1;
      for (ch = 0; ch < edd_pkg::NUM_CHAN; ch++) begin
        carry_right[ch] = '0;
        part_left[ch]   = '0;
        part_here[ch]   = '0;
      end
    end
    x = int'(col_pos);
    if (x >= w) x = w - 1;
    last = (x == w - 1);
    chan_in[0] = px.red_in;
    chan_in[1] = px.green_in;
    chan_in[2] = px.blue_in;
    for (ch = 0; ch < edd_pkg::NUM_CHAN; ch++) begin
      above        = top_row ? 0 : int'(err_line[x][ch]);
      sum          = int'(chan_in[ch]) + above + int'(carry_right[ch]);
      chan_out[ch] = nearest_level(sum);
      // The error is taken from the unclamped sum.
      e = sum - int'(chan_out[ch]);
      if (x > 0) err_line[x-1][ch] = err_t'(int'(part_left[ch]) + (e * 3) / 16);
      part_left[ch]   = err_t'(int'(part_here[ch]) + (e * 5) / 16);
      part_here[ch]   = err_t'(e / 16);
      carry_right[ch] = err_t'((e * 7) / 16);
      if (last) begin
        err_line[x][ch] = part_left[ch];
        part_left[ch]   = '0;
        part_here[ch]   = '0;
        carry_right[ch] = '0;
      end
    end
    if (last) begin
      col_pos = '0;
      top_row = 1'b0;
    end else begin
      col_pos = COL_W'(x + 1);
    end
    res.red_out   = chan_out[0];
    res.green_out = chan_out[1];
    res.blue_out  = chan_out[2];
    res.alpha_out = px.alpha_in;
  endtask

  function automatic int unsigned field_mismatch(input string field,
                                                 input logic [edd_pkg::CHAN_W-1:0] want,
                                                 input logic [edd_pkg::CHAN_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    edd_pkg::pix_out_t want;
    edd_pkg::pix_out_t got;
    int unsigned       errs;
    errs = 0;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (dithered_pixels.size() == 0) begin
          $display("%0t: output transaction with none expected, expected none, actual %h",
                   $time, got);
          errs++;
        end else begin
          want = dithered_pixels.pop_front();
          errs += field_mismatch("red_out", want.red_out, got.red_out);
          errs += field_mismatch("green_out", want.green_out, got.green_out);
          errs += field_mismatch("blue_out", want.blue_out, got.blue_out);
          errs += field_mismatch("alpha_out", want.alpha_out, got.alpha_out);
        end
      end
      if (in_valid_i && in_ready_i) begin
        dither_pixel(in_data_i, want);
        dithered_pixels.insert(dithered_pixels.size(), want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        width_reg = cfg_data_i;
      end
    end
    fail_count_o <= fail_count_o + errs;
    pending_o    <= dithered_pixels.size();
  end

endmodule

>>> test/tb_error_diffusion_dither_rgb.sv
`timescale 1ns / 1ps
// Testbench top for error_diffusion_dither_rgb: drives pixel and width transactions
// with random idling on both sides and gives the verdict. Depends on edd_pkg, the
// block itself and edd_dither_checker, which predicts and compares every result.
module tb_error_diffusion_dither_rgb;

  localparam int unsigned MAX_W           = edd_pkg::MAX_WIDTH_DEFAULT;
  localparam int unsigned RANDOM_PIXELS   = 810;
  localparam int unsigned DRAIN_CYCLES    = 20;
  // Widest value the register can hold; the block must treat it as MAX_W.
  localparam logic [edd_pkg::WIDTH_W-1:0] WIDTH_TOP = 11'd2047;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  edd_pkg::pix_in_t            in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  edd_pkg::pix_out_t           out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [edd_pkg::WIDTH_W-1:0] cfg_data  = edd_pkg::WIDTH_RESET;
  int unsigned                 fail_count;
  int unsigned                 pending;

  // When set, neither side idles: the sender offers back-to-back transactions
  // and the receiver never stalls.
  bit                 no_idle    = 1'b0;
  int unsigned        ready_hold = 0;
  // Effective row width as the block sees it. Whenever it grows, the next pixel
  // is made to start a frame, so that no line entry is read before it is written.
  int unsigned        eff_width  = MAX_W;
  bit                 need_frame = 1'b0;

  error_diffusion_dither_rgb #(
    .MAX_WIDTH (MAX_W)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  edd_dither_checker #(
    .MAX_WIDTH (MAX_W)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side: ready is held high or low for random stretches. Most stalls
  // are short, a few are long, and none occur while no_idle is set.
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      case ($urandom_range(0, 19))
        0:       ready_hold <= $urandom_range(20, 40);
        1, 2, 3: ready_hold <= $urandom_range(4, 12);
        default: ready_hold <= $urandom_range(0, 2);
      endcase
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end
  end

  // A channel value: mostly uniform, with the extremes and values close to an
  // output level mixed in, so that rounding at both edges of a level is hit.
  function automatic logic [edd_pkg::CHAN_W-1:0] random_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return edd_pkg::CHAN_W'(
                        edd_pkg::LEVEL_VALUE[$urandom_range(0, edd_pkg::LEVEL_NUM - 1)]
                        + $urandom_range(0, 8) - 4);
      default: return edd_pkg::CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic edd_pkg::pix_in_t random_pixel();
    edd_pkg::pix_in_t px;
    px.red_in      = random_chan();
    px.green_in    = random_chan();
    px.blue_in     = random_chan();
    px.alpha_in    = edd_pkg::CHAN_W'($urandom());
    px.frame_start = ($urandom_range(0, 47) == 0);
    return px;
  endfunction

  // Offers one pixel transaction after a random gap and returns at the clock
  // edge at which it is accepted. Valid is left high, so that a following call
  // with no gap keeps it high without a second assignment in the same step.
  task automatic send_pixel(input edd_pkg::pix_in_t px);
    edd_pkg::pix_in_t item;
    int unsigned      gap;
    int unsigned      roll;
    item = px;
    if (need_frame) begin
      item.frame_start = 1'b1;
      need_frame       = 1'b0;
    end
    if (no_idle) begin
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 50)      gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 10);
      else                gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_rgb(input logic [edd_pkg::CHAN_W-1:0] r,
                          input logic [edd_pkg::CHAN_W-1:0] g,
                          input logic [edd_pkg::CHAN_W-1:0] b,
                          input logic [edd_pkg::CHAN_W-1:0] a,
                          input logic fs);
    edd_pkg::pix_in_t px;
    px.red_in      = r;
    px.green_in    = g;
    px.blue_in     = b;
    px.alpha_in    = a;
    px.frame_start = fs;
    send_pixel(px);
  endtask

  // Withdraws the sender and waits until every pixel offered so far has come
  // back. The first edge lets the checker count the transaction accepted last.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes the width register once the block is idle.
  task automatic set_width(input logic [edd_pkg::WIDTH_W-1:0] new_w);
    int unsigned next_eff;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= new_w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    next_eff = int'(new_w);
    if (next_eff < 1) next_eff = 1;
    if (next_eff > MAX_W) next_eff = MAX_W;
    if (next_eff > eff_width) need_frame = 1'b1;
    eff_width = next_eff;
  endtask

  initial begin
    int unsigned                 random_sent;
    int unsigned                 burst;
    logic [edd_pkg::WIDTH_W-1:0] new_w;
    random_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset width of 1024 is in force. The first row after reset reads no
    // error from above, so these pixels need no start-of-frame flag.
    send_rgb(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_rgb(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_rgb(8'd128, 8'd4, 8'd250, 8'd170, 1'b0);

    // A width of zero behaves as one, so every pixel ends its row and only the
    // error from above is carried on.
    set_width('0);
    send_rgb(8'd13, 8'd242, 8'd5, 8'h5a, 1'b1);
    send_rgb(8'd14, 8'd241, 8'd4, 8'ha5, 1'b0);
    send_rgb(8'd255, 8'd0, 8'd133, 8'd1, 1'b0);

    // Rows of two pixels. The carried error pushes red above 255 and green
    // below zero, so both clamps are taken; the second row reads the first.
    set_width(11'd2);
    send_rgb(8'd250, 8'd5, 8'd123, 8'd254, 1'b0);
    send_rgb(8'd255, 8'd0, 8'd131, 8'd2, 1'b0);
    send_rgb(8'd251, 8'd5, 8'd14, 8'd3, 1'b0);
    send_rgb(8'd255, 8'd0, 8'd242, 8'd4, 1'b0);

    // The width is lowered mid-row: the column already lies past the new last
    // pixel, so the next pixel is handled as the last of its row.
    set_width(11'd5);
    send_rgb(8'd100, 8'd200, 8'd33, 8'd10, 1'b0);
    send_rgb(8'd101, 8'd199, 8'd34, 8'd11, 1'b0);
    send_rgb(8'd102, 8'd198, 8'd35, 8'd12, 1'b0);
    set_width(11'd2);
    send_rgb(8'd103, 8'd197, 8'd36, 8'd13, 1'b0);
    send_rgb(8'd104, 8'd196, 8'd37, 8'd14, 1'b0);
    send_rgb(8'd105, 8'd195, 8'd38, 8'd15, 1'b0);

    // The widest register value stands for 1024. A start of frame in the middle
    // of a row clears the column and every carry.
    set_width(WIDTH_TOP);
    send_rgb(8'd77, 8'd178, 8'd9, 8'd128, 1'b0);
    send_rgb(8'd76, 8'd179, 8'd10, 8'd127, 1'b0);
    send_rgb(8'd75, 8'd180, 8'd11, 8'd126, 1'b1);
    send_rgb(8'd74, 8'd181, 8'd12, 8'd125, 1'b0);

    // Random phases: a new width for each, mostly short rows so that many rows
    // complete and the error from above is exercised, with the extremes mixed in.
    while (random_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 19))
        0:       new_w = '0;
        1:       new_w = 11'd1;
        2:       new_w = WIDTH_TOP;
        3:       new_w = edd_pkg::WIDTH_RESET;
        4:       new_w = edd_pkg::WIDTH_W'($urandom_range(MAX_W + 1, 2046));
        5, 6, 7: new_w = edd_pkg::WIDTH_W'($urandom_range(17, 64));
        default: new_w = edd_pkg::WIDTH_W'($urandom_range(1, 16));
      endcase
      set_width(new_w);
      no_idle <= ($urandom_range(0, 3) == 0);
      burst = $urandom_range(4, 60);
      repeat (burst) begin
        send_pixel(random_pixel());
        random_sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run needs.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/edd_pkg.sv
rtl/core/edd_ram.sv
rtl/core/error_diffusion_dither_rgb.sv
test/edd_dither_checker.sv
test/tb_error_diffusion_dither_rgb.sv
